[design/random_file_offset_picker_unit_macros.svh]
// Assertion macros used by the checker file.
`ifndef RANDOM_FILE_OFFSET_PICKER_UNIT_MACROS_SVH
`define RANDOM_FILE_OFFSET_PICKER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RFOP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RFOP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rfop_pkg.sv]
package rfop_pkg;

    localparam int DATA_W         = 31;
    localparam int SEED_W         = 32;
    localparam int NUM_SLICES_DEF = 32;

    localparam logic [SEED_W-1:0] SEED_ZERO_SUB = 32'd123459876;
    localparam logic [DATA_W-1:0] SCHRAGE_Q     = 31'd127773;
    localparam logic [14:0]       SCHRAGE_A     = 15'd16807;
    localparam logic [11:0]       SCHRAGE_R     = 12'd2836;
    localparam logic [DATA_W-1:0] PM_MOD        = 31'h7fffffff;

    // floor(2^32 / Q): estimate for the reciprocal divide by Q
    localparam logic [SEED_W-1:0] SCHRAGE_Q_RCP =
        SEED_W'((64'd1 << SEED_W) / 64'(SCHRAGE_Q));

    // Constant-divide operand selection
    typedef logic [1:0] div_sel_t;
    localparam div_sel_t DIV_SEL_SEED   = 2'd0;  // seed / Q
    localparam div_sel_t DIV_SEL_SIZE   = 2'd1;  // data size / slices
    localparam div_sel_t DIV_SEL_XSLICE = 2'd2;  // x / slices

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        div_sel_t div_sel;
        logic     rcp_mul;
        logic     rcp_back;
        logic     rcp_fix;
        logic     cap_prod;
        logic     cap_x;
        logic     cap_len;
        logic     chk_len;
        logic     cap_slice;
        logic     cap_off;
        logic     mul_pos;
        logic     add_pos;
        logic     mul_t1;
        logic     mul_t2;
        logic     add_seed;
        logic     load_out;
    } rfop_cmd_t;

    typedef struct packed {
        logic div_done;
        logic slice_zero;
        logic req_draw;
    } rfop_sts_t;

endpackage

[design/rfop_div.sv]
module rfop_div
    import rfop_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SEED_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] remainder
);

    localparam int CNT_W = $clog2(SEED_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [SEED_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [SEED_W-1:0] trial;
    logic              ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SEED_W-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? DATA_W'(trial - {1'b0, dvs_reg}) : trial[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SEED_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SEED_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[design/rfop_datapath.sv]
module rfop_datapath
    import rfop_pkg::*;
#(
    parameter int NUM_SLICES = NUM_SLICES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rfop_cmd_t         cmd,
    output rfop_sts_t         sts,
    input  logic              req_type,
    input  logic [5:0]        seconds,
    input  logic [5:0]        minutes,
    input  logic [4:0]        hours,
    input  logic              cfg_we,
    input  logic [DATA_W-1:0] data_size,
    output logic [DATA_W-1:0] position,
    output logic              size_fault
);

    localparam int                SLICE_W    = $clog2(NUM_SLICES);
    localparam int                CDIV_W     = 17;
    localparam logic [CDIV_W-1:0] SLICES_D   = CDIV_W'(NUM_SLICES);
    localparam logic [SEED_W-1:0] RCP_SLICES = SEED_W'((64'd1 << SEED_W) / 64'(NUM_SLICES));

    logic              req_reg;
    logic [5:0]        sec_reg;
    logic [5:0]        min_reg;
    logic [4:0]        hr_reg;
    logic [DATA_W-1:0] data_size_reg;
    logic [SEED_W-1:0] seed_reg;
    logic [SEED_W-1:0] prod_a_reg;
    logic [26:0]       prod_b_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] slice_len_reg;
    logic [SLICE_W-1:0] slice_reg;
    logic [DATA_W-1:0] off_reg;
    logic [DATA_W-1:0] pmul_reg;
    logic [DATA_W-1:0] pos_reg;
    logic              fault_reg;
    logic [11:0]       tm1_reg;
    logic [16:0]       tm2_reg;
    logic [DATA_W-1:0] position_reg;
    logic              size_fault_reg;

    logic [2*SEED_W-1:0] rcp_prod_reg;
    logic [SEED_W-1:0]   rcp_back_reg;
    logic [SEED_W-1:0]   rcp_quo_reg;
    logic [SEED_W-1:0]   rcp_rem_reg;

    logic [SEED_W-1:0] cdv_dividend;
    logic [SEED_W-1:0] cdv_recip;
    logic [CDIV_W-1:0] cdv_divisor;
    logic [SEED_W-1:0] rcp_q_est;
    logic [SEED_W-1:0] rcp_r_est;
    logic [SEED_W-1:0] rcp_r_adj;
    logic              rcp_over;

    logic              div_done;
    logic [DATA_W-1:0] div_rem;
    logic [SEED_W:0]   diff;
    logic [SEED_W:0]   x_wrap;

    // Operands of the constant divides; held for all three steps
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_SEL_SEED:
            begin
                cdv_dividend = (seed_reg == '0) ? SEED_ZERO_SUB : seed_reg;
                cdv_recip    = SCHRAGE_Q_RCP;
                cdv_divisor  = SCHRAGE_Q[CDIV_W-1:0];
            end
            DIV_SEL_SIZE:
            begin
                cdv_dividend = {1'b0, data_size_reg};
                cdv_recip    = RCP_SLICES;
                cdv_divisor  = SLICES_D;
            end
            default:
            begin
                // x / slices
                cdv_dividend = {1'b0, x_reg};
                cdv_recip    = RCP_SLICES;
                cdv_divisor  = SLICES_D;
            end
        endcase
    end

    // The reciprocal estimate is the true quotient or one below it;
    // one compare and subtract settles it.
    always_comb
    begin
        rcp_q_est = rcp_prod_reg[2*SEED_W-1:SEED_W];
        rcp_r_est = cdv_dividend - rcp_back_reg;
        rcp_r_adj = rcp_r_est - SEED_W'(cdv_divisor);
        rcp_over  = (rcp_r_est >= SEED_W'(cdv_divisor));
    end

    rfop_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  ({1'b0, x_reg}),
        .divisor   (slice_len_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Schrage difference; fold negative values back by the modulus
    always_comb
    begin
        diff   = {1'b0, prod_a_reg} - {6'd0, prod_b_reg};
        x_wrap = diff[SEED_W] ? (diff + {2'b00, PM_MOD}) : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_size_reg <= '0;
            seed_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                data_size_reg <= data_size;
            end
            if (cmd.cap_x)
            begin
                seed_reg <= {1'b0, x_wrap[DATA_W-1:0]};
            end
            else if (cmd.add_seed)
            begin
                seed_reg <= seed_reg + {15'd0, tm2_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= req_type;
            sec_reg <= seconds;
            min_reg <= minutes;
            hr_reg  <= hours;
        end
        if (cmd.rcp_mul)
        begin
            rcp_prod_reg <= {{SEED_W{1'b0}}, cdv_dividend} * {{SEED_W{1'b0}}, cdv_recip};
        end
        if (cmd.rcp_back)
        begin
            rcp_back_reg <= rcp_q_est * SEED_W'(cdv_divisor);
        end
        if (cmd.rcp_fix)
        begin
            rcp_quo_reg <= rcp_over ? (rcp_q_est + 32'd1) : rcp_q_est;
            rcp_rem_reg <= rcp_over ? rcp_r_adj : rcp_r_est;
        end
        if (cmd.cap_prod)
        begin
            prod_a_reg <= {17'd0, SCHRAGE_A} * {15'd0, rcp_rem_reg[16:0]};
            prod_b_reg <= {15'd0, SCHRAGE_R} * {11'd0, rcp_quo_reg[15:0]};
        end
        if (cmd.cap_x)
        begin
            x_reg <= x_wrap[DATA_W-1:0];
        end
        if (cmd.cap_len)
        begin
            slice_len_reg <= rcp_quo_reg[DATA_W-1:0];
        end
        if (cmd.chk_len)
        begin
            pos_reg   <= '0;
            fault_reg <= (slice_len_reg == '0);
        end
        if (cmd.cap_slice)
        begin
            slice_reg <= rcp_rem_reg[SLICE_W-1:0];
        end
        if (cmd.cap_off)
        begin
            off_reg <= div_rem;
        end
        if (cmd.mul_pos)
        begin
            pmul_reg <= slice_len_reg * DATA_W'(slice_reg);
        end
        if (cmd.add_pos)
        begin
            pos_reg <= pmul_reg + off_reg;
        end
        if (cmd.mul_t1)
        begin
            tm1_reg <= {6'd0, sec_reg} * {6'd0, min_reg};
        end
        if (cmd.mul_t2)
        begin
            tm2_reg <= {5'd0, tm1_reg} * {12'd0, hr_reg};
        end
        if (cmd.load_out)
        begin
            position_reg   <= pos_reg;
            size_fault_reg <= fault_reg;
        end
    end

    assign sts.div_done   = div_done;
    assign sts.slice_zero = (slice_len_reg == '0);
    assign sts.req_draw   = req_reg;

    assign position   = position_reg;
    assign size_fault = size_fault_reg;

endmodule

[design/rfop_ctrl.sv]
module rfop_ctrl
    import rfop_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  rfop_sts_t sts,
    output rfop_cmd_t cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_Q_MUL  = 5'd1;
    localparam logic [4:0] S_Q_BACK = 5'd2;
    localparam logic [4:0] S_Q_FIX  = 5'd3;
    localparam logic [4:0] S_PROD   = 5'd4;
    localparam logic [4:0] S_X      = 5'd5;
    localparam logic [4:0] S_L_MUL  = 5'd6;
    localparam logic [4:0] S_L_BACK = 5'd7;
    localparam logic [4:0] S_L_FIX  = 5'd8;
    localparam logic [4:0] S_L_CAP  = 5'd9;
    localparam logic [4:0] S_CHECK  = 5'd10;
    localparam logic [4:0] S_S_MUL  = 5'd11;
    localparam logic [4:0] S_S_BACK = 5'd12;
    localparam logic [4:0] S_S_FIX  = 5'd13;
    localparam logic [4:0] S_O_GO   = 5'd14;
    localparam logic [4:0] S_O_WAIT = 5'd15;
    localparam logic [4:0] S_P_MUL  = 5'd16;
    localparam logic [4:0] S_P_ADD  = 5'd17;
    localparam logic [4:0] S_T1     = 5'd18;
    localparam logic [4:0] S_T2     = 5'd19;
    localparam logic [4:0] S_T3     = 5'd20;
    localparam logic [4:0] S_RES    = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_Q_MUL;
                end
            end
            S_Q_MUL:
            begin
                // reseed-only requests skip straight to the time product
                if (sts.req_draw)
                begin
                    cmd.div_sel = DIV_SEL_SEED;
                    cmd.rcp_mul = 1'b1;
                    state_next  = S_Q_BACK;
                end
                else
                begin
                    state_next = S_T1;
                end
            end
            S_Q_BACK:
            begin
                cmd.div_sel  = DIV_SEL_SEED;
                cmd.rcp_back = 1'b1;
                state_next   = S_Q_FIX;
            end
            S_Q_FIX:
            begin
                cmd.div_sel = DIV_SEL_SEED;
                cmd.rcp_fix = 1'b1;
                state_next  = S_PROD;
            end
            S_PROD:
            begin
                cmd.cap_prod = 1'b1;
                state_next   = S_X;
            end
            S_X:
            begin
                cmd.cap_x  = 1'b1;
                state_next = S_L_MUL;
            end
            S_L_MUL:
            begin
                cmd.div_sel = DIV_SEL_SIZE;
                cmd.rcp_mul = 1'b1;
                state_next  = S_L_BACK;
            end
            S_L_BACK:
            begin
                cmd.div_sel  = DIV_SEL_SIZE;
                cmd.rcp_back = 1'b1;
                state_next   = S_L_FIX;
            end
            S_L_FIX:
            begin
                cmd.div_sel = DIV_SEL_SIZE;
                cmd.rcp_fix = 1'b1;
                state_next  = S_L_CAP;
            end
            S_L_CAP:
            begin
                cmd.cap_len = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.chk_len = 1'b1;
                state_next  = sts.slice_zero ? S_T1 : S_S_MUL;
            end
            S_S_MUL:
            begin
                cmd.div_sel = DIV_SEL_XSLICE;
                cmd.rcp_mul = 1'b1;
                state_next  = S_S_BACK;
            end
            S_S_BACK:
            begin
                cmd.div_sel  = DIV_SEL_XSLICE;
                cmd.rcp_back = 1'b1;
                state_next   = S_S_FIX;
            end
            S_S_FIX:
            begin
                cmd.div_sel = DIV_SEL_XSLICE;
                cmd.rcp_fix = 1'b1;
                state_next  = S_O_GO;
            end
            S_O_GO:
            begin
                cmd.cap_slice = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_O_WAIT;
            end
            S_O_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_off = 1'b1;
                    state_next  = S_P_MUL;
                end
            end
            S_P_MUL:
            begin
                cmd.mul_pos = 1'b1;
                state_next  = S_P_ADD;
            end
            S_P_ADD:
            begin
                cmd.add_pos = 1'b1;
                state_next  = S_T1;
            end
            S_T1:
            begin
                cmd.mul_t1 = 1'b1;
                state_next = S_T2;
            end
            S_T2:
            begin
                cmd.mul_t2 = 1'b1;
                state_next = S_T3;
            end
            S_T3:
            begin
                cmd.add_seed = 1'b1;
                state_next   = sts.req_draw ? S_RES : S_IDLE;
            end
            S_RES:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[design/random_file_offset_picker_unit.sv]
// A draw runs from input transfer to result valid through three 3-step reciprocal divides
// and one 32-step radix-2 remainder pass; a zero slice length skips the last divide and the pass.
// A reseed-only request occupies the block and produces no result.
// One request at a time: a new request is taken only back in idle, and a finished draw waits
// until the output register is free, so a stalled result side holds off further requests.
// Reset (rst_n, async, active low): seed and data_size clear to zero, no result pending.
module random_file_offset_picker_unit
    import rfop_pkg::*;
#(
    parameter int NUM_SLICES = NUM_SLICES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic [5:0]        seconds,
    input  logic [5:0]        minutes,
    input  logic [4:0]        hours,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] position,
    output logic              size_fault,
    // configuration write channel (data_size register)
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DATA_W-1:0] data_size
);

    rfop_cmd_t cmd;
    rfop_sts_t sts;

    // Configuration writes must only land while the block is idle; the block itself
    // does not enforce it, and it accepts every transfer at once.
    assign cfg_ready = 1'b1;

    // Sequencer: walks the Schrage step, the slice-length division, the slice
    // and offset picks, and the time perturbation of the seed.
    rfop_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: seed, reciprocal-multiply unit for the divides by constants,
    // radix-2 divider for the offset within a slice, two-stage multiplies and
    // the output register that parts the result side from the request side.
    rfop_datapath #(
        .NUM_SLICES (NUM_SLICES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_type   (req_type),
        .seconds    (seconds),
        .minutes    (minutes),
        .hours      (hours),
        .cfg_we     (cfg_valid),
        .data_size  (data_size),
        .position   (position),
        .size_fault (size_fault)
    );

endmodule

[design/rfop_checker.sv]
`include "random_file_offset_picker_unit_macros.svh"

module rfop_checker
    import rfop_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DATA_W-1:0] position,
    input  logic              size_fault
);

    // A stalled result keeps its payload
    `RFOP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(position) && $stable(size_fault), "result changed while stalled")

    // A zero slice length always reports position zero
    `RFOP_ASSERT_IMP(a_fault_pos, out_valid && size_fault, position == '0, "fault with nonzero position")

    // The block works one request at a time
    `RFOP_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "ready right after a request transfer")

    // A result only appears while a request is in progress
    `RFOP_ASSERT_IMP(a_res_src, $rose(out_valid), !$past(in_ready), "result appeared from idle")

endmodule

bind random_file_offset_picker_unit rfop_checker u_rfop_checker (.*);

[sim/tb_random_file_offset_picker_unit.sv]
`timescale 1ns / 100ps

module tb_random_file_offset_picker_unit;
    import rfop_pkg::*;

    localparam int NUM_SLICES       = NUM_SLICES_DEF;
    // Largest seed perturbation one request can add: raw 63 * 63 * 31.
    localparam int MAX_TIME_PRODUCT = 63 * 63 * 31;
    localparam logic [DATA_W-1:0] DATA_MAX = '1;
    localparam int PHASE_ITEMS      = 115;
    localparam int RANDOM_PHASES    = 8;
    // Long receiver hold-off, well past two full draws.
    localparam int HOLD_CYCLES      = 480;
    // Idle time before a register write: covers a trailing reseed-only request.
    localparam int SETTLE_CYCLES    = 16;
    // Quiet time at the end: longer than one draw, to catch stray results.
    localparam int TAIL_CYCLES      = 200;
    // Cycles without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT      = 4000;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic [DATA_W-1:0] position;
        logic              size_fault;
    } pick_t;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic              req_type   = 1'b0;
    logic [5:0]        seconds    = '0;
    logic [5:0]        minutes    = '0;
    logic [4:0]        hours      = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [DATA_W-1:0] position;
    logic              size_fault;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [DATA_W-1:0] data_size  = '0;

    // Predictor state: a private copy of the seed and the size register.
    logic [SEED_W-1:0] pick_seed      = '0;
    logic [DATA_W-1:0] pick_data_size = '0;
    pick_t             expected_picks[$];

    int  mismatch_count = 0;
    bit  tx_gaps_on     = 1'b1;
    bit  rx_gaps_on     = 1'b1;
    int  hold_requests  = 0;

    random_file_offset_picker_unit #(
        .NUM_SLICES (NUM_SLICES)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .seconds    (seconds),
        .minutes    (minutes),
        .hours      (hours),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .position   (position),
        .size_fault (size_fault),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .data_size  (data_size)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // One minimal-standard step by Schrage's split. A zero seed is swapped for
    // the fixed substitute first; seeds above 2^31-1 go through unchanged.
    function automatic logic [SEED_W-1:0] schrage_step(input logic [SEED_W-1:0] seed_in);
        logic [SEED_W-1:0] base;
        longint            hi_l;
        longint            lo_l;
        longint            mul_a;
        longint            mul_r;
        longint            modulus;
        longint            x;
        base    = (seed_in == '0) ? SEED_ZERO_SUB : seed_in;
        hi_l    = base / SCHRAGE_Q;
        lo_l    = base % SCHRAGE_Q;
        mul_a   = SCHRAGE_A;
        mul_r   = SCHRAGE_R;
        modulus = PM_MOD;
        x       = mul_a * lo_l - mul_r * hi_l;
        if (x < 0)
            x = x + modulus;
        return x[SEED_W-1:0];
    endfunction

    // Advance the predictor for one accepted request and queue the pick it yields.
    task automatic predict_pick(input bit draw, input logic [5:0] secs,
                                input logic [5:0] mins, input logic [4:0] hrs);
        logic [SEED_W-1:0] x;
        logic [31:0]       slice_len;
        logic [31:0]       slice_idx;
        logic [31:0]       offset;
        logic [31:0]       pos;
        pick_t             pick;
        if (draw)
        begin
            x         = schrage_step(pick_seed);
            pick_seed = x;
            slice_len = pick_data_size / NUM_SLICES;
            if (slice_len == 0)
            begin
                pick.position   = '0;
                pick.size_fault = 1'b1;
            end
            else
            begin
                slice_idx       = x % NUM_SLICES;
                offset          = x % slice_len;
                pos             = slice_len * slice_idx + offset;
                pick.position   = pos[DATA_W-1:0];
                pick.size_fault = 1'b0;
            end
            expected_picks.push_back(pick);
        end
        // Time perturbation applies to every request and wraps at 32 bits.
        pick_seed = pick_seed + 32'(secs) * 32'(mins) * 32'(hrs);
    endtask

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Offer one request and hold it until the transfer. Valid is left high on
    // return so that a back-to-back request needs no second assignment.
    task automatic send_request(input bit draw, input logic [5:0] secs,
                                input logic [5:0] mins, input logic [4:0] hrs);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= draw;
        seconds  <= secs;
        minutes  <= mins;
        hours    <= hrs;
        do
            @(posedge clk);
        while (!in_ready);
        predict_pick(draw, secs, mins, hrs);
    endtask

    // Drop valid, wait for every queued pick, then let the block settle.
    task automatic drain_picks(input int settle);
        in_valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_data_size(input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        data_size <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        pick_data_size = value;
        cfg_valid <= 1'b0;
    endtask

    // Zero seed at the first draw, with the reset size and a size just below
    // one byte per slice: both must flag the fault with position zero.
    task automatic test_zero_seed_and_fault();
        write_data_size('0);
        send_request(1'b0, 6'd0, 6'd0, 5'd0);
        send_request(1'b1, 6'd0, 6'd0, 5'd0);
        drain_picks(SETTLE_CYCLES);
        write_data_size(DATA_W'(NUM_SLICES - 1));
        send_request(1'b1, 6'd59, 6'd59, 5'd23);
        drain_picks(SETTLE_CYCLES);
    endtask

    // Smallest nonzero slice length and the largest data size, with the time
    // fields at zero, at their nominal top and at their raw bit limit.
    task automatic test_size_extremes();
        write_data_size(DATA_W'(NUM_SLICES));
        send_request(1'b1, 6'd59, 6'd59, 5'd23);
        send_request(1'b0, 6'd7, 6'd8, 5'd9);
        send_request(1'b1, 6'd1, 6'd2, 5'd3);
        drain_picks(SETTLE_CYCLES);
        write_data_size(DATA_MAX);
        send_request(1'b1, 6'd63, 6'd63, 5'd31);
        send_request(1'b1, 6'd0, 6'd0, 5'd0);
        send_request(1'b1, 6'd32, 6'd16, 5'd16);
        drain_picks(SETTLE_CYCLES);
    endtask

    // Push the seed past 2^31-1: find a draw whose result sits within one
    // maximal time product of the top, reach it with reseed-only requests,
    // then draw with the maximal product and draw again from the wide seed.
    task automatic test_seed_above_31_bits();
        logic [SEED_W-1:0] start;
        logic [SEED_W-1:0] cand;
        logic [SEED_W-1:0] x;
        logic [5:0]        fit_s;
        logic [5:0]        fit_m;
        logic [4:0]        fit_h;
        int                k;
        int                p;
        int                a;
        int                b;
        int                hit_k;
        bit                found;
        found = 1'b0;
        hit_k = 0;
        fit_s = '0;
        fit_m = '0;
        fit_h = '0;
        start = pick_seed;
        for (k = 0; k < 8 && !found; k++)
        begin
            for (p = 0; p <= MAX_TIME_PRODUCT && !found; p++)
            begin
                cand = start + 32'(k * MAX_TIME_PRODUCT) + 32'(p);
                x    = schrage_step(cand);
                if (x >= 32'h8000_0000 - 32'(MAX_TIME_PRODUCT))
                begin
                    // The offset p must itself be a product of the time fields.
                    if (p == 0)
                        found = 1'b1;
                    for (a = 1; a <= 63 && !found; a++)
                    begin
                        for (b = 1; b <= 63 && !found; b++)
                        begin
                            if (p % (a * b) == 0 && p / (a * b) >= 1 && p / (a * b) <= 31)
                            begin
                                fit_s = 6'(a);
                                fit_m = 6'(b);
                                fit_h = 5'(p / (a * b));
                                found = 1'b1;
                            end
                        end
                    end
                    if (found)
                        hit_k = k;
                end
            end
        end
        if (found)
        begin
            repeat (hit_k) send_request(1'b0, 6'd63, 6'd63, 5'd31);
            send_request(1'b0, fit_s, fit_m, fit_h);
            send_request(1'b1, 6'd63, 6'd63, 5'd31);
            send_request(1'b1, 6'd0, 6'd0, 5'd0);
        end
        drain_picks(SETTLE_CYCLES);
    endtask

    // Hold the result side off for a long stretch while draws keep coming, so
    // the output register fills and the request side stalls.
    task automatic test_output_backpressure();
        tx_gaps_on = 1'b0;
        hold_requests++;
        repeat (6) send_request(1'b1, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                5'($urandom_range(0, 31)));
        drain_picks(SETTLE_CYCLES);
        tx_gaps_on = 1'b1;
    endtask

    // Random traffic in phases, one data size per phase; the last phase runs
    // with no idling on either side.
    task automatic test_random_traffic();
        logic [DATA_W-1:0] size_val;
        logic [5:0]        secs;
        logic [5:0]        mins;
        logic [4:0]        hrs;
        bit                draw;
        int                phase;
        int                n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       size_val = DATA_W'($urandom_range(0, NUM_SLICES - 1));
                1:       size_val = DATA_W'($urandom_range(NUM_SLICES, 4095));
                3:       size_val = DATA_MAX;
                4:       size_val = '0;
                6:       size_val = DATA_W'($urandom_range(NUM_SLICES, 2 * NUM_SLICES - 1));
                default: size_val = DATA_W'($urandom);
            endcase
            write_data_size(size_val);
            tx_gaps_on = (phase % 3 != 1) && (phase < RANDOM_PHASES - 1);
            rx_gaps_on = (phase % 3 != 2) && (phase < RANDOM_PHASES - 1);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                draw = ($urandom_range(0, 9) < 7);
                // Mostly real clock times; now and then the raw field limits.
                if ($urandom_range(0, 7) == 0)
                begin
                    secs = 6'($urandom_range(0, 63));
                    mins = 6'($urandom_range(0, 63));
                    hrs  = 5'($urandom_range(0, 31));
                end
                else
                begin
                    secs = 6'($urandom_range(0, 59));
                    mins = 6'($urandom_range(0, 59));
                    hrs  = 5'($urandom_range(0, 23));
                end
                send_request(draw, secs, mins, hrs);
            end
            if (phase < RANDOM_PHASES - 1)
                drain_picks(SETTLE_CYCLES);
        end
    endtask

    // Result side: short random stalls, plus one long hold on request. The
    // hold is counted here, not in the stimulus.
    initial
    begin : result_receiver
        int hold_seen;
        int stall_left;
        hold_seen  = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen  = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && rx_gaps_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare every result transfer against the oldest queued pick.
    always @(posedge clk)
    begin : pick_checker
        pick_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_picks.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result position %0d fault %0b",
                                       position, size_fault));
            end
            else
            begin
                want = expected_picks.pop_front();
                if (position !== want.position || size_fault !== want.size_fault)
                    log_mismatch($sformatf("expected position %0d fault %0b, got position %0d fault %0b",
                                           want.position, want.size_fault,
                                           position, size_fault));
            end
        end
    end

    // Hang detector: any transfer on any channel resets the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no transfer for %0d cycles", $realtime, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : run_tests
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_seed_and_fault();
        test_size_extremes();
        test_seed_above_31_bits();
        test_output_backpressure();
        test_random_traffic();
        // Wait out the last results, then a quiet tail for anything extra.
        drain_picks(TAIL_CYCLES);
        if (mismatch_count == 0 && expected_picks.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            if (expected_picks.size() != 0)
                $display("%0d expected results never arrived", expected_picks.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
